@@ design/gshare_branch_target_predictor_core_defines.svh @@
// ----------------------------------------------------------------------------
// gshare branch target predictor: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GSHARE_BRANCH_TARGET_PREDICTOR_CORE_DEFINES_SVH
`define GSHARE_BRANCH_TARGET_PREDICTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define GBTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbtp: same-cycle check failed");

// Next-cycle implication.
`define GBTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbtp: next-cycle check failed");

`endif

@@ design/gbtp_pkg.sv @@
// ----------------------------------------------------------------------------
// gbtp_pkg
// Types and constants shared by the predictor core and its target table.
// ----------------------------------------------------------------------------
package gbtp_pkg;

  typedef enum logic [1:0] {
    CMD_PREDICT = 2'd0,
    CMD_PEEK    = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // One table entry.
  typedef struct packed {
    logic        valid;
    logic [1:0]  ctr;
    logic [31:0] baddr;
    logic [31:0] target;
  } entry_t;

  localparam logic [31:0] PC_STEP     = 32'd4;
  localparam logic [1:0]  CTR_INSTALL = 2'd2;

endpackage

@@ design/gbtp_table.sv @@
// ----------------------------------------------------------------------------
// gbtp_table
// Target table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbtp_table #(
  parameter int ADDR_W = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  gbtp_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output gbtp_pkg::entry_t     rd_data
);
  import gbtp_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/gshare_branch_target_predictor_core.sv @@
// ----------------------------------------------------------------------------
// gshare_branch_target_predictor_core
// gshare-indexed branch target table with a one-shot fix-up after mispredict.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  -------  ---------  -----------------  -----------------------------------
//  in_*     input      in_valid/in_stall  cmd, pc, correct_pc, was_mispredicted,
//                                         taken, branch_op, hist_used
//  out_*    output     out_valid/out_stall next_pc, history_now
//
//  Sequence: predict, peek, update without mispredict and the unused command
//  pass through accept and one table read (ST_RD1); a mispredict that finds a
//  valid entry adds a second read (ST_RD2), since training re-reads the table
//  at the shifted-history index, as the table has a single read port.
//  Reset: a clearing pass writes every entry, with in_stall high throughout.
//  Stalls: a finished word parks in a hold register while out_stall is high;
//  input is stalled only during the clearing pass, while an item is in flight
//  or while the hold is full.
`include "gshare_branch_target_predictor_core_defines.svh"

module gshare_branch_target_predictor_core #(
  parameter int TABLE_ORDER = 10,
  parameter int HIST_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_pc,
  input  logic [31:0] in_correct_pc,
  input  logic        in_was_mispredicted,
  input  logic        in_taken,
  input  logic        in_branch_op,
  input  logic [15:0] in_hist_used,
  // result word
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic [15:0] out_history_now
);
  import gbtp_pkg::*;

  localparam int IW = TABLE_ORDER;
  localparam int HW = HIST_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } state_t;

  // Table index: (addr >> 1) xor low two history bits, cut to table size.
  function automatic logic [IW-1:0] tbl_idx(input logic [31:0] addr,
                                            input logic [HW-1:0] hist);
    logic [IW-1:0] hi;
    hi = IW'(addr >> 1);
    return hi ^ IW'(hist[1:0]);
  endfunction

  // Train on a mispredict: drop the counter, replace a weak or empty entry.
  function automatic entry_t train_miss(input entry_t e,
                                        input logic [31:0] pc,
                                        input logic [31:0] cpc);
    entry_t        r;
    logic   [1:0]  c;
    r = e;
    c = e.ctr;
    if (c != 2'd0) begin
      c = c - 2'd1;
    end
    if (c < CTR_INSTALL || !e.valid) begin
      r.valid  = 1'b1;
      r.ctr    = CTR_INSTALL;
      r.baddr  = pc;
      r.target = cpc;
    end else begin
      r.ctr = c;
    end
    return r;
  endfunction

  // Train on a correct branch: install if empty, else bump (wraps 3 -> 0).
  function automatic entry_t train_hit(input entry_t e,
                                       input logic [31:0] pc,
                                       input logic [31:0] cpc);
    entry_t r;
    r = e;
    if (!e.valid) begin
      r.valid  = 1'b1;
      r.ctr    = CTR_INSTALL;
      r.baddr  = pc;
      r.target = cpc;
    end else begin
      r.ctr = e.ctr + 2'd1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state_r,       state_nxt;
  logic [IW-1:0]     clr_idx_r,     clr_idx_nxt;
  cmd_t              cmd_r,         cmd_nxt;
  logic [31:0]       pc_r,          pc_nxt;
  logic [31:0]       cpc_r,         cpc_nxt;
  logic              mis_r,         mis_nxt;
  logic              tk_r,          tk_nxt;
  logic              isb_r,         isb_nxt;
  logic [HW-1:0]     hist_r,        hist_nxt;
  logic [IW-1:0]     idx_r,         idx_nxt;
  logic [HW-1:0]     gh_r,          gh_nxt;
  logic              fix_pend_r,    fix_pend_nxt;
  logic [31:0]       fix_tgt_r,     fix_tgt_nxt;
  logic [HW-1:0]     fix_hist_r,    fix_hist_nxt;
  logic              out_valid_r,   out_valid_nxt;
  logic [31:0]       out_npc_r,     out_npc_nxt;
  logic [15:0]       out_hist_r,    out_hist_nxt;
  logic              hold_valid_r,  hold_valid_nxt;
  logic [31:0]       hold_npc_r,    hold_npc_nxt;
  logic [15:0]       hold_hist_r,   hold_hist_nxt;

  // Table port
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  entry_t            rd_data;

  gbtp_table #(
    .ADDR_W (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // --------------------------------------------------------------------------
  // Datapath and sequencing
  // --------------------------------------------------------------------------
  logic              in_accept;
  logic              out_free;
  logic [HW-1:0]     in_hist;
  logic [IW-1:0]     in_idx;
  logic              hit;
  logic [31:0]       look_npc;
  logic [31:0]       pc_plus;
  logic [HW-1:0]     hist_sh;
  logic              finish;
  logic [31:0]       res_npc;
  logic              upd_miss;

  // Accepting only from idle with an empty hold lets every item finish
  // into either the output register or the hold, never both full.
  assign in_stall  = (state_r != ST_IDLE) || hold_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_hist  = HW'(in_hist_used);
  assign in_idx   = tbl_idx(in_pc, (cmd_t'(in_cmd) == CMD_UPDATE) ? in_hist : gh_r);
  assign pc_plus  = pc_r + PC_STEP;
  assign hit      = rd_data.valid && (rd_data.baddr == pc_r);
  assign look_npc = hit ? rd_data.target : pc_plus;
  assign hist_sh  = {hist_r[HW-2:0], tk_r};
  assign upd_miss = (cmd_r == CMD_UPDATE) && mis_r;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    cmd_nxt        = cmd_r;
    pc_nxt         = pc_r;
    cpc_nxt        = cpc_r;
    mis_nxt        = mis_r;
    tk_nxt         = tk_r;
    isb_nxt        = isb_r;
    hist_nxt       = hist_r;
    idx_nxt        = idx_r;
    gh_nxt         = gh_r;
    fix_pend_nxt   = fix_pend_r;
    fix_tgt_nxt    = fix_tgt_r;
    fix_hist_nxt   = fix_hist_r;
    out_valid_nxt  = out_valid_r;
    out_npc_nxt    = out_npc_r;
    out_hist_nxt   = out_hist_r;
    hold_valid_nxt = hold_valid_r;
    hold_npc_nxt   = hold_npc_r;
    hold_hist_nxt  = hold_hist_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = in_idx;
    finish         = 1'b0;
    res_npc        = '0;

    // Drop a taken word, then drain the hold into the free slot.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (hold_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_npc_nxt    = hold_npc_r;
      out_hist_nxt   = hold_hist_r;
      hold_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IW'(1);
        if (clr_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = cmd_t'(in_cmd);
          pc_nxt    = in_pc;
          cpc_nxt   = in_correct_pc;
          mis_nxt   = in_was_mispredicted;
          tk_nxt    = in_taken;
          isb_nxt   = in_branch_op;
          hist_nxt  = in_hist;
          idx_nxt   = in_idx;
          rd_en     = 1'b1;
          rd_addr   = in_idx;
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        case (cmd_r)
          CMD_PREDICT: begin
            finish = 1'b1;
            if (fix_pend_r) begin
              fix_pend_nxt = 1'b0;
              gh_nxt       = fix_hist_r;
              res_npc      = fix_tgt_r;
            end else begin
              res_npc = look_npc;
              if (hit) begin
                gh_nxt = {gh_r[HW-2:0], (look_npc != pc_plus)};
              end
            end
          end
          CMD_PEEK: begin
            finish  = 1'b1;
            res_npc = look_npc;
          end
          CMD_UPDATE: begin
            if (mis_r) begin
              fix_pend_nxt = 1'b1;
              fix_tgt_nxt  = cpc_r;
              fix_hist_nxt = hist_sh;
              if (rd_data.valid) begin
                // Valid entry: retrain at the shifted-history index.
                rd_en     = 1'b1;
                rd_addr   = tbl_idx(pc_r, hist_sh);
                idx_nxt   = tbl_idx(pc_r, hist_sh);
                state_nxt = ST_RD2;
              end else begin
                finish  = 1'b1;
                wr_en   = 1'b1;
                wr_data = train_miss(rd_data, pc_r, cpc_r);
              end
            end else if (isb_r) begin
              finish  = 1'b1;
              wr_en   = 1'b1;
              wr_data = train_hit(rd_data, pc_r, cpc_r);
            end else begin
              finish = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      ST_RD2: begin
        finish  = 1'b1;
        wr_en   = 1'b1;
        wr_data = train_miss(rd_data, pc_r, cpc_r);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = ST_IDLE;
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_npc_nxt   = res_npc;
        out_hist_nxt  = 16'(gh_nxt);
      end else begin
        hold_valid_nxt = 1'b1;
        hold_npc_nxt   = res_npc;
        hold_hist_nxt  = 16'(gh_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      gh_r         <= '0;
      fix_pend_r   <= 1'b0;
      fix_tgt_r    <= '0;
      fix_hist_r   <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      gh_r         <= gh_nxt;
      fix_pend_r   <= fix_pend_nxt;
      fix_tgt_r    <= fix_tgt_nxt;
      fix_hist_r   <= fix_hist_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    pc_r        <= pc_nxt;
    cpc_r       <= cpc_nxt;
    mis_r       <= mis_nxt;
    tk_r        <= tk_nxt;
    isb_r       <= isb_nxt;
    hist_r      <= hist_nxt;
    idx_r       <= idx_nxt;
    out_npc_r   <= out_npc_nxt;
    out_hist_r  <= out_hist_nxt;
    hold_npc_r  <= hold_npc_nxt;
    hold_hist_r <= hold_hist_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_npc_r;
  assign out_history_now = out_hist_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `GBTP_ASSERT_NXT(a_accept_reads, in_accept, state_r == ST_RD1)
  `GBTP_ASSERT_IMP(a_hold_needs_out, hold_valid_r, out_valid_r)
  `GBTP_ASSERT_IMP(a_rd2_after_miss, state_r == ST_RD2, $past(state_r == ST_RD1 && upd_miss))
  `GBTP_ASSERT_IMP(a_fixup_from_update, $rose(fix_pend_r), $past(upd_miss))
  `GBTP_ASSERT_IMP(a_write_when_busy, wr_en, state_r != ST_IDLE)

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: gshare branch target predictor core testbench
// Drives predict, peek, update and unused-command words into the core. A
// mirror of the target table, the global history and the fix-up latch
// predicts every result, and each result is checked in order, field by field.
// The run varies sender gaps and receiver stalls across several phases.
// ----------------------------------------------------------------------------
module tb_top;
  import gbtp_pkg::*;

  localparam int TBL_ORDER = 10;
  localparam int TBL_SLOTS = 1 << TBL_ORDER;

  typedef logic [TBL_ORDER-1:0] slot_t;

  // One input word as the core sees it.
  typedef struct {
    cmd_t        cmd;
    logic [31:0] pc;
    logic [31:0] correct_pc;
    logic        mispredicted;
    logic        taken;
    logic        branch_op;
    logic [15:0] hist_used;
  } fetch_req_t;

  // One result word.
  typedef struct {
    logic [31:0] next_pc;
    logic [15:0] history;
  } fetch_ans_t;

  // Shadow copy of the predictor; holds the results still owed by the core.
  class btb_mirror;
    bit          vld  [TBL_SLOTS];
    bit [1:0]    ctr  [TBL_SLOTS];
    logic [31:0] baddr[TBL_SLOTS];
    logic [31:0] tgt  [TBL_SLOTS];
    logic [15:0] ghist;
    bit          fix_armed;
    logic [31:0] fix_tgt;
    logic [15:0] fix_hist;
    fetch_ans_t  owed[$];
    int          errs;

    function new();
      foreach (vld[i]) begin
        vld[i]   = 1'b0;
        ctr[i]   = 2'd0;
        baddr[i] = '0;
        tgt[i]   = '0;
      end
      ghist     = '0;
      fix_armed = 1'b0;
      fix_tgt   = '0;
      fix_hist  = '0;
      errs      = 0;
    endfunction

    function slot_t slot_of(logic [31:0] pc, logic [15:0] h);
      return slot_t'((pc >> 1) ^ {30'b0, h[1:0]});
    endfunction

    // Hit when the slot is valid and tagged with this pc; miss falls through.
    function bit lookup(logic [31:0] pc, output logic [31:0] nxt);
      slot_t s;
      s = slot_of(pc, ghist);
      if (vld[s] && baddr[s] == pc) begin
        nxt = tgt[s];
        return 1'b1;
      end
      nxt = pc + PC_STEP;
      return 1'b0;
    endfunction

    function void install(slot_t s, logic [31:0] pc, logic [31:0] target);
      vld[s]   = 1'b1;
      ctr[s]   = CTR_INSTALL;
      baddr[s] = pc;
      tgt[s]   = target;
    endfunction

    // Advance the shadow state by one accepted word and queue its result.
    function fetch_ans_t absorb(fetch_req_t r);
      fetch_ans_t  a;
      slot_t       s;
      logic [15:0] shifted;
      logic [31:0] nxt;
      bit          hit;
      a.next_pc = '0;
      case (r.cmd)
        CMD_PREDICT: begin
          if (fix_armed) begin
            fix_armed = 1'b0;
            ghist     = fix_hist;
            a.next_pc = fix_tgt;
          end else begin
            hit       = lookup(r.pc, nxt);
            a.next_pc = nxt;
            if (hit) ghist = {ghist[14:0], (nxt != r.pc + PC_STEP)};
          end
        end
        CMD_PEEK: begin
          hit       = lookup(r.pc, nxt);
          a.next_pc = nxt;
        end
        CMD_UPDATE: begin
          s = slot_of(r.pc, r.hist_used);
          if (r.mispredicted) begin
            // the branch flag is ignored on a mispredict
            shifted   = {r.hist_used[14:0], r.taken};
            fix_armed = 1'b1;
            fix_tgt   = r.correct_pc;
            fix_hist  = shifted;
            if (vld[s]) s = slot_of(r.pc, shifted);
            if (ctr[s] != 2'd0) ctr[s] = ctr[s] - 2'd1;
            if (ctr[s] < CTR_INSTALL || !vld[s]) install(s, r.pc, r.correct_pc);
          end else if (r.branch_op) begin
            if (!vld[s]) install(s, r.pc, r.correct_pc);
            else ctr[s] = ctr[s] + 2'd1;
          end
        end
        default: ;
      endcase
      a.history = ghist;
      owed.push_back(a);
      return a;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errs++;
    endtask

    task check_answer(logic [31:0] next_pc, logic [15:0] history);
      fetch_ans_t e;
      if (owed.size() == 0) begin
        report($sformatf("result with none owed: next_pc %h history %h", next_pc, history));
      end else begin
        e = owed.pop_front();
        if (next_pc !== e.next_pc)
          report($sformatf("next_pc got %h want %h", next_pc, e.next_pc));
        if (history !== e.history)
          report($sformatf("history_now got %h want %h", history, e.history));
      end
    endtask
  endclass

  // Cycles with no word moving on either channel before the run is called hung.
  // Covers the clearing pass after reset and the long receiver hold-off.
  localparam int STUCK_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1850;
  localparam int POOL = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = 2'd0;
  logic [31:0] in_pc = '0;
  logic [31:0] in_correct_pc = '0;
  logic        in_was_mispredicted = 1'b0;
  logic        in_taken = 1'b0;
  logic        in_branch_op = 1'b0;
  logic [15:0] in_hist_used = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_pc;
  logic [15:0] out_history_now;

  btb_mirror   mirror;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          stuck_cycles = 0;
  int          words_sent = 0;
  logic [31:0] pool_pc [POOL];
  logic [31:0] pool_tgt[POOL];

  gshare_branch_target_predictor_core #(
    .TABLE_ORDER(TBL_ORDER),
    .HIST_BITS  (16)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_pc              (in_pc),
    .in_correct_pc      (in_correct_pc),
    .in_was_mispredicted(in_was_mispredicted),
    .in_taken           (in_taken),
    .in_branch_op       (in_branch_op),
    .in_hist_used       (in_hist_used),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_pc        (out_next_pc),
    .out_history_now    (out_history_now)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a requested stretch of cycles.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check every result word on the edge it is taken; track channel activity.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      mirror.check_answer(out_next_pc, out_history_now);
    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin : watchdog
    do @(posedge clk); while (stuck_cycles < STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Offer one word, hold it until taken, then feed it to the mirror. The
  // mirror learns of the word on the same edge the core takes it, so later
  // stimulus can read the mirror's history without a race.
  task automatic send_word(fetch_req_t r, output fetch_ans_t a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= r.cmd;
    in_pc               <= r.pc;
    in_correct_pc       <= r.correct_pc;
    in_was_mispredicted <= r.mispredicted;
    in_taken            <= r.taken;
    in_branch_op        <= r.branch_op;
    in_hist_used        <= r.hist_used;
    do @(posedge clk); while (in_stall);
    a = mirror.absorb(r);
    words_sent++;
  endtask

  task automatic offer(cmd_t cmd, logic [31:0] pc, logic [31:0] cpc, logic mis,
                       logic tk, logic isb, logic [15:0] hist);
    fetch_req_t r;
    fetch_ans_t a;
    r.cmd          = cmd;
    r.pc           = pc;
    r.correct_pc   = cpc;
    r.mispredicted = mis;
    r.taken        = tk;
    r.branch_op    = isb;
    r.hist_used    = hist;
    send_word(r, a);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.owed.size() != 0);
  endtask

  // A branch as a pipeline sees it: predict (maybe peek first), then resolve
  // with the history that was live at predict time.
  task automatic branch_round();
    fetch_req_t  r;
    fetch_ans_t  a;
    int          k;
    logic [15:0] h;
    logic [31:0] actual;
    logic        tk;
    k = $urandom_range(POOL - 1);
    h = mirror.ghist;
    r.pc           = pool_pc[k];
    r.correct_pc   = $urandom;
    r.mispredicted = 1'($urandom_range(1));
    r.taken        = 1'($urandom_range(1));
    r.branch_op    = 1'($urandom_range(1));
    r.hist_used    = 16'($urandom);
    if ($urandom_range(99) < 20) begin
      r.cmd = CMD_PEEK;
      send_word(r, a);
    end
    r.cmd = CMD_PREDICT;
    send_word(r, a);
    tk = ($urandom_range(99) < 60);
    if (!tk) actual = pool_pc[k] + PC_STEP;
    else if ($urandom_range(99) < 10) actual = $urandom;
    else actual = pool_tgt[k];
    r.cmd          = CMD_UPDATE;
    r.correct_pc   = actual;
    r.taken        = tk;
    r.branch_op    = ($urandom_range(99) < 95);
    r.hist_used    = h;
    r.mispredicted = (actual != a.next_pc);
    if ($urandom_range(99) < 5) r.mispredicted = ~r.mispredicted;
    send_word(r, a);
  endtask

  // Unstructured word: any command, any field values.
  task automatic noise_word();
    fetch_req_t r;
    fetch_ans_t a;
    r.cmd          = cmd_t'($urandom_range(3));
    r.pc           = $urandom_range(1) ? pool_pc[$urandom_range(POOL - 1)] : $urandom;
    r.correct_pc   = $urandom;
    r.mispredicted = 1'($urandom_range(1));
    r.taken        = 1'($urandom_range(1));
    r.branch_op    = 1'($urandom_range(1));
    r.hist_used    = 16'($urandom);
    send_word(r, a);
  endtask

  initial begin : stimulus
    int   phase;
    int   last_phase;
    logic [31:0] br;
    mirror = new();

    // Pool of branch addresses; the last eight alias the first eight's slots
    // with different tags, so tag misses on valid slots happen often.
    for (int i = 0; i < POOL; i++) begin
      if (i < 16) pool_pc[i] = $urandom;
      else pool_pc[i] = pool_pc[i - 16] ^ (32'h1 << $urandom_range(31, 11));
      pool_tgt[i] = $urandom;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: field extremes, every command, the corner cases.
    br = 32'h0000_1000;
    offer(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);
    offer(CMD_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);  // pc+4 wraps
    offer(CMD_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    offer(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    offer(CMD_UPDATE, br, 32'h0000_8000, 1'b0, 1'b1, 1'b1, 16'h0);     // install
    offer(CMD_PREDICT, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);            // hit
    offer(CMD_UPDATE, br, 32'h0000_8000, 1'b0, 1'b1, 1'b1, 16'h0);     // counter to 3
    offer(CMD_UPDATE, br, 32'h0000_8000, 1'b0, 1'b1, 1'b1, 16'h0);     // wraps to 0
    offer(CMD_UPDATE, br, 32'h0000_8000, 1'b0, 1'b1, 1'b1, 16'h0);
    offer(CMD_UPDATE, br, 32'h0000_9000, 1'b1, 1'b1, 1'b1, 16'h0);     // mispredict, valid
    offer(CMD_PEEK, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);               // fix-up untouched
    offer(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);         // fix-up delivered
    offer(CMD_PREDICT, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);
    offer(CMD_UPDATE, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0, 16'hFFFF); // non-branch miss
    offer(CMD_PREDICT, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);
    offer(CMD_UPDATE, br, 32'h0, 1'b0, 1'b1, 1'b0, 16'h0);             // not a branch
    offer(CMD_UPDATE, br, 32'h0000_9000, 1'b0, 1'b1, 1'b1, 16'h1);
    offer(CMD_UPDATE, br, 32'h0000_A000, 1'b1, 1'b1, 1'b1, 16'h0);     // counter drops to 2, entry kept
    offer(CMD_PREDICT, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);
    offer(CMD_PEEK, br, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);
    offer(CMD_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF);
    offer(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 16'h0);

    // Random words, phase by phase: no idling, sparse sender, heavy stall,
    // both sides idling, then a long receiver hold-off to fill the core.
    last_phase = -1;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      phase = (words_sent / 310) % 5;
      if (phase != last_phase) begin
        case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin
            drain_results();  // sender pause until the core is empty
            idle_pct = 78; stall_pct = 0;
          end
          2: begin idle_pct = 0;  stall_pct = 78; end
          3: begin idle_pct = 24; stall_pct = 24; end
          default: begin
            idle_pct = 0; stall_pct = 0;
            hold_req = 300;  // sender keeps offering while results back up
          end
        endcase
        last_phase = phase;
      end
      if ($urandom_range(99) < 70) branch_round();
      else noise_word();
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mirror.errs == 0 && mirror.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
